// File: hw/rtl/p2vr_pkg.sv
// Shared constants for the pixel-to-view-ray block.
`timescale 1ns / 1ps
`default_nettype none
package p2vr_pkg;

  // Fixed field widths.
  localparam int PIXEL_BITS     = 12;
  localparam int DIR_BITS       = 16;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_INDEX_BITS = 3;

  // Normalization precision.
  localparam int NORM_BITS  = 31;
  localparam int SQRT_STEPS = 32;
  localparam int QUOT_BITS  = 15;
  localparam int FRAC_BITS  = 14;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_ROW0    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_ROW1    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_ROW2    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_EXTENT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP  = 3'd4;

  // Reset values: identity matrix, unit half extents, step of 82/4096.
  localparam logic [47:0] ROT_ROW0_RST    = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW1_RST    = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW2_RST    = 48'h4000_0000_0000;
  localparam logic [31:0] HALF_EXTENT_RST = 32'h1000_1000;
  localparam logic [31:0] PIXEL_STEP_RST  = 32'h0052_0052;

endpackage
`default_nettype wire

// File: hw/rtl/p2vr_pix_if.sv
// Pixel coordinate channel.
`timescale 1ns / 1ps
`default_nettype none
interface p2vr_pix_if;
  logic                            valid;
  logic                            ready;
  logic [p2vr_pkg::PIXEL_BITS-1:0] pixel_x;
  logic [p2vr_pkg::PIXEL_BITS-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/p2vr_dir_if.sv
// Ray direction channel.
`timescale 1ns / 1ps
`default_nettype none
interface p2vr_dir_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [p2vr_pkg::DIR_BITS-1:0] dir_x;
  logic signed [p2vr_pkg::DIR_BITS-1:0] dir_y;
  logic signed [p2vr_pkg::DIR_BITS-1:0] dir_z;
  logic                                 zero_length;
  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output zero_length, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z,
                input zero_length, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pixel_to_view_ray.sv
// Pinhole camera primary ray direction generator, fully pipelined.
// Depth: 58 register stages, from the canvas point register to the output register.
// Throughput: one transaction per cycle while the output is not stalled; the square
// root (one result bit per stage, 32 stages) and the three dividers (one
// quotient bit per stage) set the depth. A stall on the output freezes the pipeline.
// Reset (synchronous) clears all valid bits and restores the identity matrix.
`timescale 1ns / 1ps
`default_nettype none
module pixel_to_view_ray #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  p2vr_pix_if.sink                                     pix,
  p2vr_dir_if.source                                   dir,
  input  wire logic                                    cfg_we,
  input  wire logic [p2vr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [p2vr_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int UB  = (COORD_BITS < p2vr_pkg::PIXEL_BITS) ? COORD_BITS
                                                          : p2vr_pkg::PIXEL_BITS;
  localparam int WW  = UB + 18;          // canvas point width, signed
  localparam int PW  = WW + 16;          // matrix product width
  localparam int CW  = WW + 18;          // rotated component width
  localparam int SHW = $clog2(CW + 1);
  localparam int NB  = p2vr_pkg::NORM_BITS;
  localparam int SQN = p2vr_pkg::SQRT_STEPS;
  localparam int QB  = p2vr_pkg::QUOT_BITS;
  localparam int FB  = p2vr_pkg::FRAC_BITS;
  localparam int NUMW = NB + FB + 1;
  localparam int NST = 9 + SQN + 1 + QB + 1;

  // Configuration registers.
  logic [47:0] rot_row [0:2];
  logic [15:0] half_w, half_h, step_x, step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= p2vr_pkg::ROT_ROW0_RST;
      rot_row[1] <= p2vr_pkg::ROT_ROW1_RST;
      rot_row[2] <= p2vr_pkg::ROT_ROW2_RST;
      {half_h, half_w} <= p2vr_pkg::HALF_EXTENT_RST;
      {step_y, step_x} <= p2vr_pkg::PIXEL_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        p2vr_pkg::REG_ROT_ROW0:    rot_row[0] <= cfg_data;
        p2vr_pkg::REG_ROT_ROW1:    rot_row[1] <= cfg_data;
        p2vr_pkg::REG_ROT_ROW2:    rot_row[2] <= cfg_data;
        p2vr_pkg::REG_HALF_EXTENT: {half_h, half_w} <= cfg_data[31:0];
        p2vr_pkg::REG_PIXEL_STEP:  {step_y, step_x} <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages move together unless the output is held.
  logic           adv;
  logic [NST-1:0] vld;

  assign adv       = !vld[NST-1] || dir.ready;
  assign pix.ready = adv;
  assign dir.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], pix.valid};
    end
  end

  // Stage 1: canvas point, 2*h - (2*p+1)*step in Q.13.
  logic        [UB:0]    odd_x, odd_y;
  logic        [UB+16:0] tx, ty;
  logic signed [WW-1:0]  wx, wy;

  assign odd_x = {pix.pixel_x[UB-1:0], 1'b1};
  assign odd_y = {pix.pixel_y[UB-1:0], 1'b1};
  assign tx = odd_x * step_x;
  assign ty = odd_y * step_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      wx <= $signed({{(WW-17){1'b0}}, half_w, 1'b0}) - $signed({1'b0, tx});
      wy <= $signed({{(WW-17){1'b0}}, half_h, 1'b0}) - $signed({1'b0, ty});
    end
  end

  // Stage 2: the nine matrix products.
  logic signed [WW-1:0] wv [0:2];
  logic signed [PW-1:0] prod [0:2][0:2];

  assign wv[0] = wx;
  assign wv[1] = wy;
  assign wv[2] = -WW'(8192);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= $signed(rot_row[i][16*j +: 16]) * wv[j];
        end
      end
    end
  end

  // Stage 3: row sums.
  logic signed [CW-1:0] comp [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        comp[i] <= $signed({{2{prod[i][0][PW-1]}}, prod[i][0]})
                 + $signed({{2{prod[i][1][PW-1]}}, prod[i][1]})
                 + $signed({{2{prod[i][2][PW-1]}}, prod[i][2]});
      end
    end
  end

  // Stage 4: magnitudes, signs and the zero-vector flag.
  logic [CW-1:0] mag_d [0:2];
  logic [3:0]    sb [4:NST-1];   // {zero, sign z, sign y, sign x}

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag_d[i] <= comp[i][CW-1] ? CW'(-comp[i]) : CW'(comp[i]);
      end
      sb[4] <= {(comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0),
                comp[2][CW-1], comp[1][CW-1], comp[0][CW-1]};
      for (int k = 5; k <= NST-1; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // Stage 5: largest magnitude.
  logic [CW-1:0] mag_e [0:2];
  logic [CW-1:0] max01, max_e;

  assign max01 = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_e <= mag_d;
      max_e <= (max01 > mag_d[2]) ? max01 : mag_d[2];
    end
  end

  // Stage 6: shift that brings the largest magnitude below 2^31.
  logic [CW-1:0]  mag_f [0:2];
  logic [SHW-1:0] blen, sh_f;

  always_comb begin
    blen = '0;
    for (int b = 0; b < CW; b++) begin
      if (max_e[b]) begin
        blen = SHW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_f <= mag_e;
      sh_f  <= (blen > SHW'(NB)) ? blen - SHW'(NB) : '0;
    end
  end

  // Stage 7: scaled magnitudes.
  logic [NB-1:0] am [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        am[i] <= NB'(mag_f[i] >> sh_f);
      end
    end
  end

  // Stage 8: squares.
  logic [NB-1:0]   am_h [0:2];
  logic [2*NB-1:0] sq [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      am_h <= am;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= am[i] * am[i];
      end
    end
  end

  // Stage 9 and the square root stages, one result bit per stage.
  logic [63:0]   sr_s [0:SQN];
  logic [63:0]   sr_r [0:SQN];
  logic [NB-1:0] sr_a [0:SQN][0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_s[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      sr_r[0] <= '0;
      sr_a[0] <= am_h;
    end
  end

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQN - 1 - k));
    logic [63:0] trial;
    assign trial = sr_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_a[k+1] <= sr_a[k];
        if (sr_s[k] >= trial) begin
          sr_s[k+1] <= sr_s[k] - trial;
          sr_r[k+1] <= (sr_r[k] >> 1) + BIT;
        end else begin
          sr_s[k+1] <= sr_s[k];
          sr_r[k+1] <= sr_r[k] >> 1;
        end
      end
    end
  end

  // Dividend with rounding term: a * 2^14 + floor(r / 2).
  logic [NUMW-1:0] dv_rem [0:QB][0:2];
  logic [QB-1:0]   dv_q   [0:QB][0:2];
  logic [31:0]     dv_r   [0:QB];
  logic [31:0]     root;

  assign root = sr_r[SQN][31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= root;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {1'b0, sr_a[SQN][i], {FB{1'b0}}} + NUMW'(root >> 1);
        dv_q[0][i]   <= '0;
      end
    end
  end

  // Restoring dividers, one quotient bit per stage, MSB first.
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BP = QB - 1 - k;
    logic [NUMW:0] rshift;
    assign rshift = (NUMW + 1)'(dv_r[k]) << BP;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= dv_r[k];
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, dv_rem[k][i]} >= rshift) begin
            dv_rem[k+1][i] <= dv_rem[k][i] - rshift[NUMW-1:0];
            dv_q[k+1][i]   <= dv_q[k][i] | (QB'(1) << BP);
          end else begin
            dv_rem[k+1][i] <= dv_rem[k][i];
            dv_q[k+1][i]   <= dv_q[k][i];
          end
        end
      end
    end
  end

  // Output register: apply signs, force zero for a zero-length vector.
  logic signed [15:0] dq [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dq[i] = $signed({1'b0, dv_q[QB][i]});
      if (sb[NST-1][3]) begin
        dq[i] = '0;
      end else if (sb[NST-1][i]) begin
        dq[i] = -dq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir.dir_x       <= dq[0];
      dir.dir_y       <= dq[1];
      dir.dir_z       <= dq[2];
      dir.zero_length <= sb[NST-1][3];
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_chan_if.sv
// Cycle counter interface used by the testbench.
`timescale 1ns / 1ps
interface tb_clk_if (input logic clk);
  int unsigned cycles;
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end
endinterface

// File: tb/tb.sv
// Testbench for pixel_to_view_ray: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic               zl;
  } ray_dir_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [p2vr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [p2vr_pkg::CFG_DATA_BITS-1:0] cfg_data;

  p2vr_pix_if pix ();
  p2vr_dir_if dir ();
  tb_clk_if ck (.clk(clk));

  pixel_to_view_ray uut (
    .clk(clk), .rst(rst), .pix(pix), .dir(dir),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers.
  logic [47:0] rot_row [3];
  logic [31:0] half_ext;
  logic [31:0] pix_step;

  ray_dir_t expected_dirs[$];
  int errors;
  int src_idle_pct;
  int snk_idle_pct;
  int quiet_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Signed Q2.14 matrix entry.
  function automatic longint entry(logic [47:0] row, int col);
    logic signed [15:0] v;
    v = row[16*col +: 16];
    return longint'(v);
  endfunction

  // Integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Computes the unit ray direction through the center of one pixel.
  function automatic ray_dir_t view_ray(logic [11:0] px, logic [11:0] py);
    longint w[3], c[3];
    longint unsigned m[3], a[3], maxm, s2, r, d;
    int sh;
    ray_dir_t res;
    w[0] = 2 * longint'(half_ext[15:0]) - (2 * longint'(px) + 1) * longint'(pix_step[15:0]);
    w[1] = 2 * longint'(half_ext[31:16]) - (2 * longint'(py) + 1) * longint'(pix_step[31:16]);
    w[2] = -8192;
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = 0;
      for (int j = 0; j < 3; j++) c[i] += entry(rot_row[i], j) * w[j];
      m[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > maxm) maxm = m[i];
    end
    res = '{0, 0, 0, 1'b0};
    if (maxm == 0) begin
      res.zl = 1'b1;
      return res;
    end
    sh = 0;
    while ((maxm >> sh) >= (64'd1 << 31)) sh++;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = m[i] >> sh;
      s2 += a[i] * a[i];
    end
    r = int_sqrt(s2);
    for (int i = 0; i < 3; i++) begin
      d = (a[i] * 16384 + (r >> 1)) / r;
      if (c[i] < 0) d = -d;
      if (i == 0) res.dx = d[15:0];
      else if (i == 1) res.dy = d[15:0];
      else res.dz = d[15:0];
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d in cycle %0d", what, got, want, ck.cycles);
    errors++;
  endtask

  // Receiver: random stalls, and each accepted transaction is checked.
  always @(posedge clk) begin
    ray_dir_t e;
    if (rst) begin
      dir.ready <= 1'b0;
    end else begin
      if (dir.valid && dir.ready) begin
        if (expected_dirs.size() == 0) begin
          report("unexpected dir_x", dir.dir_x, 0);
        end else begin
          e = expected_dirs.pop_front();
          if (dir.dir_x !== e.dx) report("dir_x", dir.dir_x, e.dx);
          if (dir.dir_y !== e.dy) report("dir_y", dir.dir_y, e.dy);
          if (dir.dir_z !== e.dz) report("dir_z", dir.dir_z, e.dz);
          if (dir.zero_length !== e.zl) report("zero_length", dir.zero_length, e.zl);
        end
      end
      dir.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (dir.valid && dir.ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sends one pixel transaction and records its expected direction.
  // Valid stays high after acceptance so that transactions can follow back to back.
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    expected_dirs.push_back(view_ray(px, py));
    do @(posedge clk); while (!pix.ready);
  endtask

  // Writes one register once the pipeline has drained.
  task automatic write_reg(logic [p2vr_pkg::CFG_INDEX_BITS-1:0] idx, logic [47:0] val);
    pix.valid <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      p2vr_pkg::REG_ROT_ROW0: rot_row[0] = val;
      p2vr_pkg::REG_ROT_ROW1: rot_row[1] = val;
      p2vr_pkg::REG_ROT_ROW2: rot_row[2] = val;
      p2vr_pkg::REG_HALF_EXTENT: half_ext = val[31:0];
      p2vr_pkg::REG_PIXEL_STEP: pix_step = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_corners();
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    send_pixel(48, 48);
    send_pixel(12'hAAA, 12'h555);
  endtask

  // Zero matrix gives the zero-length flag.
  task automatic test_zero_vector();
    write_reg(p2vr_pkg::REG_ROT_ROW0, 0);
    write_reg(p2vr_pkg::REG_ROT_ROW1, 0);
    write_reg(p2vr_pkg::REG_ROT_ROW2, 0);
    send_pixel(5, 7);
    send_pixel(12'hFFF, 0);
    write_reg(p2vr_pkg::REG_ROT_ROW0, p2vr_pkg::ROT_ROW0_RST);
    write_reg(p2vr_pkg::REG_ROT_ROW1, p2vr_pkg::ROT_ROW1_RST);
    write_reg(p2vr_pkg::REG_ROT_ROW2, 48'hFFFF_FFFF_FFFF);
    send_pixel(0, 0);
  endtask

  // Extreme and degenerate register settings.
  task automatic test_extremes();
    write_reg(p2vr_pkg::REG_ROT_ROW0, 48'h8000_8000_8000);
    write_reg(p2vr_pkg::REG_ROT_ROW1, 48'h7FFF_7FFF_7FFF);
    write_reg(p2vr_pkg::REG_ROT_ROW2, 48'h8000_7FFF_8000);
    write_reg(p2vr_pkg::REG_HALF_EXTENT, 32'hFFFF_FFFF);
    write_reg(p2vr_pkg::REG_PIXEL_STEP, 32'hFFFF_FFFF);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    write_reg(p2vr_pkg::REG_HALF_EXTENT, 0);
    write_reg(p2vr_pkg::REG_PIXEL_STEP, 0);
    send_pixel(100, 200);
    write_reg(p2vr_pkg::REG_PIXEL_STEP, 32'h0001_FFFF);
    send_pixel(12'h800, 12'h7FF);
  endtask

  // Random pixels under a random configuration.
  task automatic test_random(int count);
    for (int k = 0; k < 5; k++) begin
      write_reg(p2vr_pkg::CFG_INDEX_BITS'(k), 48'({$urandom, $urandom}));
    end
    for (int n = 0; n < count; n++) send_pixel(12'($urandom), 12'($urandom));
  endtask

  initial begin
    errors = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    rot_row[0] = p2vr_pkg::ROT_ROW0_RST;
    rot_row[1] = p2vr_pkg::ROT_ROW1_RST;
    rot_row[2] = p2vr_pkg::ROT_ROW2_RST;
    half_ext = p2vr_pkg::HALF_EXTENT_RST;
    pix_step = p2vr_pkg::PIXEL_STEP_RST;
    src_idle_pct = 34;
    snk_idle_pct = 47;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_zero_vector();
    test_extremes();
    test_random(180);
    src_idle_pct = 47;
    snk_idle_pct = 34;
    test_random(180);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(180);
    pix.valid <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
